FILE: rtl/wma_pkg.sv
// ----------------------------------------------------------------------------
// Weighted moment accumulator package
// Shared widths, defaults and the control bundle of the serial arithmetic units.
// ----------------------------------------------------------------------------
package wma_pkg;

    // Port widths of the item and result fields.
    localparam int KIND_W   = 2;
    localparam int COORD_W  = 16;
    localparam int WEIGHT_W = 16;
    localparam int COUNT_W  = 16;
    localparam int WTOT_W   = 32;
    localparam int MEAN_W   = 24;
    localparam int VAR_W    = 38;
    localparam int COV_W    = 39;

    // Defaults for the top-level parameters.
    localparam int DEF_COORD_BITS  = 16;
    localparam int DEF_WEIGHT_BITS = 16;
    localparam int DEF_COUNT_BITS  = 16;

    // Accumulator and datapath widths.
    localparam int FIRST_W = 48;
    localparam int SUM_W   = 64;
    localparam int OPND_W  = 64;
    localparam int PROD_W  = 128;
    localparam int LEN_W   = 7;

    // Item kinds.
    typedef enum logic [KIND_W-1:0] {
        KIND_ADD   = 2'd0,
        KIND_SUB   = 2'd1,
        KIND_CLEAR = 2'd2,
        KIND_NONE  = 2'd3
    } kind_t;

    // Control bundle handed to a serial unit: a start strobe and a step count.
    typedef struct packed {
        logic             start;
        logic [LEN_W-1:0] len;
    } op_ctrl_t;

endpackage

FILE: rtl/wma_mul.sv
// ----------------------------------------------------------------------------
// Bit-serial multiplier
// Shift-and-add multiplier that retires one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module wma_mul (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  wma_pkg::op_ctrl_t           ctrl,
    input  logic [wma_pkg::OPND_W-1:0]  op_a,
    input  logic [wma_pkg::OPND_W-1:0]  op_b,
    output logic                        done,
    output logic [wma_pkg::PROD_W-1:0]  product
);
    import wma_pkg::*;

    logic [PROD_W-1:0] acc_reg;
    logic [PROD_W-1:0] a_sh_reg;
    logic [OPND_W-1:0] b_sh_reg;
    logic [LEN_W-1:0]  cnt_reg;
    logic              busy_reg;
    logic              done_reg;

    // One multiplier bit per cycle; the multiplicand shifts up as the bits go by.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= !ctrl.start && busy_reg && (cnt_reg == LEN_W'(1));
            if (ctrl.start) begin
                acc_reg  <= '0;
                a_sh_reg <= PROD_W'(op_a);
                b_sh_reg <= op_b;
                cnt_reg  <= ctrl.len;
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                if (b_sh_reg[0]) begin
                    acc_reg <= acc_reg + a_sh_reg;
                end
                a_sh_reg <= a_sh_reg << 1;
                b_sh_reg <= b_sh_reg >> 1;
                cnt_reg  <= cnt_reg - 1'b1;
                if (cnt_reg == LEN_W'(1)) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule

FILE: rtl/wma_div.sv
// ----------------------------------------------------------------------------
// Bit-serial divider
// Restoring divider that produces one quotient bit per cycle, with a flag for
// quotients that do not fit 64 bits.
// ----------------------------------------------------------------------------
module wma_div (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  wma_pkg::op_ctrl_t           ctrl,
    input  logic [wma_pkg::PROD_W-1:0]  num,
    input  logic [wma_pkg::OPND_W-1:0]  den,
    output logic                        done,
    output logic [wma_pkg::OPND_W-1:0]  quot,
    output logic                        big
);
    import wma_pkg::*;

    logic [PROD_W-1:0] n_sh_reg;
    logic [OPND_W-1:0] den_reg;
    logic [OPND_W-1:0] rem_reg;
    logic [OPND_W-1:0] q_reg;
    logic              big_reg;
    logic [LEN_W-1:0]  cnt_reg;
    logic              busy_reg;
    logic              done_reg;

    logic [OPND_W:0]   rem_sh;
    logic [OPND_W:0]   rem_sub;
    logic              fits;

    // Trial subtraction for the next numerator bit.
    always_comb begin
        rem_sh  = {rem_reg, n_sh_reg[PROD_W-1]};
        rem_sub = rem_sh - {1'b0, den_reg};
        fits    = (rem_sh >= {1'b0, den_reg});
    end

    // The numerator arrives left aligned; len bits of it are shifted through.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= !ctrl.start && busy_reg && (cnt_reg == LEN_W'(1));
            if (ctrl.start) begin
                n_sh_reg <= num;
                den_reg  <= den;
                rem_reg  <= '0;
                q_reg    <= '0;
                big_reg  <= 1'b0;
                cnt_reg  <= ctrl.len;
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                n_sh_reg <= n_sh_reg << 1;
                rem_reg  <= fits ? rem_sub[OPND_W-1:0] : rem_sh[OPND_W-1:0];
                q_reg    <= {q_reg[OPND_W-2:0], fits};
                big_reg  <= big_reg | q_reg[OPND_W-1];
                cnt_reg  <= cnt_reg - 1'b1;
                if (cnt_reg == LEN_W'(1)) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    assign done = done_reg;
    assign quot = q_reg;
    assign big  = big_reg;

endmodule

FILE: rtl/weighted_moment_accumulator_3d.sv
// ----------------------------------------------------------------------------
// Weighted moment accumulator, 3D
// Keeps exact weighted sums of points and reports count, weight sum, means,
// variances and covariances in fixed point with 8 fractional bits.
//
//   channel  dir  handshake          payload
//   s_       in   s_valid/s_ready    kind, pos_x, pos_y, pos_z, weight
//   m_       out  m_valid/m_ready    error, hit_count, weight_total, means,
//                                    variances, covariances
//
// One item at a time. An accepted add or subtract runs fifteen update products
// and then the report, both on the shared bit-serial multiplier and divider
// (one bit per cycle). Clear and rejected items skip the update; with a zero
// weight sum the report skips the serial units and gives zero statistics. Reset
// clears all sums. A stalled result waits in the output register while the
// next item is already being taken.
// ----------------------------------------------------------------------------
module weighted_moment_accumulator_3d #(
    parameter int COORD_BITS  = wma_pkg::DEF_COORD_BITS,
    parameter int WEIGHT_BITS = wma_pkg::DEF_WEIGHT_BITS,
    parameter int COUNT_BITS  = wma_pkg::DEF_COUNT_BITS
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [wma_pkg::KIND_W-1:0]         s_kind,
    input  logic signed [wma_pkg::COORD_W-1:0] s_pos_x,
    input  logic signed [wma_pkg::COORD_W-1:0] s_pos_y,
    input  logic signed [wma_pkg::COORD_W-1:0] s_pos_z,
    input  logic [wma_pkg::WEIGHT_W-1:0]       s_weight,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic                               m_error,
    output logic [wma_pkg::COUNT_W-1:0]        m_hit_count,
    output logic [wma_pkg::WTOT_W-1:0]         m_weight_total,
    output logic signed [wma_pkg::MEAN_W-1:0]  m_mean_x,
    output logic signed [wma_pkg::MEAN_W-1:0]  m_mean_y,
    output logic signed [wma_pkg::MEAN_W-1:0]  m_mean_z,
    output logic [wma_pkg::VAR_W-1:0]          m_var_x,
    output logic [wma_pkg::VAR_W-1:0]          m_var_y,
    output logic [wma_pkg::VAR_W-1:0]          m_var_z,
    output logic signed [wma_pkg::COV_W-1:0]   m_cov_xy,
    output logic signed [wma_pkg::COV_W-1:0]   m_cov_yz,
    output logic signed [wma_pkg::COV_W-1:0]   m_cov_zx
);
    import wma_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_UPD,
        ST_RBEGIN,
        ST_RW2,
        ST_RMEAN,
        ST_RVA,
        ST_RVB,
        ST_RVDIV,
        ST_RCA,
        ST_RCB,
        ST_RCDIV,
        ST_DONE
    } state_t;

    localparam int PART_W = 96;
    localparam int DIFF_W = 99;
    localparam int MAG_W  = 97;
    localparam logic [LEN_W-1:0] LEN_WSUM  = LEN_W'(WTOT_W);
    localparam logic [LEN_W-1:0] LEN_FIRST = LEN_W'(FIRST_W);
    localparam logic [LEN_W-1:0] LEN_MEAN  = LEN_W'(FIRST_W + 8);
    localparam logic [LEN_W-1:0] LEN_WIDE  = LEN_W'(MAG_W + 8);
    localparam logic [LEN_W-1:0] LEN_COORD = LEN_W'(COORD_BITS);
    localparam logic [LEN_W-1:0] LEN_WGT   = LEN_W'(WEIGHT_BITS);
    localparam logic [OPND_W-1:0] MEAN_LIM = OPND_W'(1) << (MEAN_W - 1);
    localparam logic [OPND_W-1:0] COV_LIM  = OPND_W'(1) << (COV_W - 1);
    localparam logic [OPND_W-1:0] VAR_MAX  = (OPND_W'(1) << VAR_W) - 1;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    // Saturating encode of a signed quotient in sign-magnitude form.
    function automatic logic [OPND_W-1:0] enc_signed(input logic neg, input logic ovf,
                                                     input logic [OPND_W-1:0] q,
                                                     input logic [OPND_W-1:0] lim);
        logic [OPND_W-1:0] qq;
        if (neg) begin
            qq = (ovf || q > lim) ? lim : q;
            return OPND_W'(0) - qq;
        end
        return (ovf || q >= lim) ? lim - 1'b1 : q;
    endfunction

    // Saturating encode of an unsigned quotient; a negative value reads as zero.
    function automatic logic [OPND_W-1:0] enc_unsigned(input logic neg, input logic ovf,
                                                       input logic [OPND_W-1:0] q,
                                                       input logic [OPND_W-1:0] lim);
        if (neg) begin
            return '0;
        end
        return (ovf || q > lim) ? lim : q;
    endfunction

    state_t                state_reg;
    logic                  wait_reg;
    logic [1:0]            idx_reg;
    logic [2:0]            sub_reg;
    kind_t                 kind_reg;
    logic                  err_reg;
    logic                  zero_reg;
    logic [OPND_W-1:0]     w_in_reg;
    logic [OPND_W-1:0]     p_reg [3];
    logic [OPND_W-1:0]     t_reg;
    logic [COUNT_BITS-1:0] count_reg;
    logic [WTOT_W-1:0]     ws_reg;
    logic [FIRST_W-1:0]    fs_reg [3];
    logic [SUM_W-1:0]      sq_reg [3];
    logic [SUM_W-1:0]      cr_reg [3];
    logic [OPND_W-1:0]     w2_reg;
    logic [PART_W-1:0]     pa_reg;
    logic [PART_W-1:0]     pb_reg;
    logic [MEAN_W-1:0]     mean_st_reg [3];
    logic [VAR_W-1:0]      var_st_reg [3];
    logic [COV_W-1:0]      cov_st_reg [3];
    logic                  m_valid_reg;
    logic                  m_error_reg;
    logic [COUNT_W-1:0]    m_hit_count_reg;
    logic [WTOT_W-1:0]     m_weight_total_reg;
    logic [MEAN_W-1:0]     m_mean_reg [3];
    logic [VAR_W-1:0]      m_var_reg [3];
    logic [COV_W-1:0]      m_cov_reg [3];

    op_ctrl_t              mul_ctrl;
    logic [OPND_W-1:0]     mul_a;
    logic [OPND_W-1:0]     mul_b;
    logic                  mul_done;
    logic [PROD_W-1:0]     mul_prod;
    op_ctrl_t              div_ctrl;
    logic [PROD_W-1:0]     div_num;
    logic [OPND_W-1:0]     div_den;
    logic                  div_done;
    logic [OPND_W-1:0]     div_q;
    logic                  div_big;

    logic                  s_accept;
    logic                  out_load;
    logic                  is_add;
    logic [OPND_W-1:0]     w_in;
    logic [WTOT_W:0]       ws_sum;
    logic                  add_err;
    logic                  sub_err;
    logic [OPND_W-1:0]     w32;
    logic [FIRST_W-1:0]    fmag0;
    logic [FIRST_W-1:0]    fmag1;
    logic [SUM_W-1:0]      cmag0;
    logic [OPND_W-1:0]     pabs0;
    logic [OPND_W-1:0]     pabs1;
    logic                  neg_a;
    logic                  neg_b;
    logic [DIFF_W-1:0]     sgn_a;
    logic [DIFF_W-1:0]     sgn_b;
    logic [DIFF_W-1:0]     diff;
    logic [DIFF_W-1:0]     diff_abs;
    logic                  diff_neg;
    logic [OPND_W-1:0]     mean_enc;
    logic [OPND_W-1:0]     var_enc;
    logic [OPND_W-1:0]     cov_enc;
    logic                  op_done;

    assign s_ready  = (state_reg == ST_IDLE);
    assign s_accept = s_valid && s_ready;
    assign out_load = (state_reg == ST_DONE) && (!m_valid_reg || m_ready);
    assign is_add   = (kind_reg == KIND_ADD);

    // Item checks against the current count and weight sum.
    always_comb begin
        w_in    = OPND_W'(s_weight[WEIGHT_BITS-1:0]);
        ws_sum  = {1'b0, ws_reg} + (WTOT_W+1)'(s_weight[WEIGHT_BITS-1:0]);
        add_err = (count_reg == COUNT_MAX) || ws_sum[WTOT_W];
        sub_err = (count_reg == '0) || ((WTOT_W+1)'(s_weight[WEIGHT_BITS-1:0]) >
                                         {1'b0, ws_reg});
    end

    // Magnitudes of the operands at the head of the rotating sum registers.
    always_comb begin
        w32   = OPND_W'(ws_reg);
        fmag0 = fs_reg[0][FIRST_W-1] ? FIRST_W'(0) - fs_reg[0] : fs_reg[0];
        fmag1 = fs_reg[1][FIRST_W-1] ? FIRST_W'(0) - fs_reg[1] : fs_reg[1];
        cmag0 = cr_reg[0][SUM_W-1] ? SUM_W'(0) - cr_reg[0] : cr_reg[0];
        pabs0 = p_reg[0][OPND_W-1] ? OPND_W'(0) - p_reg[0] : p_reg[0];
        pabs1 = p_reg[1][OPND_W-1] ? OPND_W'(0) - p_reg[1] : p_reg[1];
    end

    // Signed difference of the two partial products, back in sign-magnitude.
    always_comb begin
        neg_a    = (state_reg == ST_RCDIV) && cr_reg[0][SUM_W-1];
        neg_b    = (state_reg == ST_RCDIV) && (fs_reg[0][FIRST_W-1] ^ fs_reg[1][FIRST_W-1]);
        sgn_a    = neg_a ? DIFF_W'(0) - DIFF_W'(pa_reg) : DIFF_W'(pa_reg);
        sgn_b    = neg_b ? DIFF_W'(0) - DIFF_W'(pb_reg) : DIFF_W'(pb_reg);
        diff     = sgn_a - sgn_b;
        diff_neg = diff[DIFF_W-1];
        diff_abs = diff_neg ? DIFF_W'(0) - diff : diff;
    end

    // Multiplier operand selection.
    always_comb begin
        mul_ctrl       = '0;
        mul_a          = '0;
        mul_b          = '0;
        mul_ctrl.start = !wait_reg;
        case (state_reg)
            ST_UPD: begin
                case (sub_reg)
                    3'd0: begin
                        mul_a        = p_reg[0];
                        mul_b        = w_in_reg;
                        mul_ctrl.len = LEN_WGT;
                    end
                    3'd1: begin
                        mul_a        = pabs0;
                        mul_b        = pabs0;
                        mul_ctrl.len = LEN_COORD;
                    end
                    3'd3: begin
                        mul_a        = p_reg[1][OPND_W-1] ? OPND_W'(0) - p_reg[0] : p_reg[0];
                        mul_b        = pabs1;
                        mul_ctrl.len = LEN_COORD;
                    end
                    default: begin
                        mul_a        = t_reg;
                        mul_b        = w_in_reg;
                        mul_ctrl.len = LEN_WGT;
                    end
                endcase
            end
            ST_RW2: begin
                mul_a        = w32;
                mul_b        = w32;
                mul_ctrl.len = LEN_WSUM;
            end
            ST_RVA: begin
                mul_a        = sq_reg[0];
                mul_b        = w32;
                mul_ctrl.len = LEN_WSUM;
            end
            ST_RVB: begin
                mul_a        = OPND_W'(fmag0);
                mul_b        = OPND_W'(fmag0);
                mul_ctrl.len = LEN_FIRST;
            end
            ST_RCA: begin
                mul_a        = cmag0;
                mul_b        = w32;
                mul_ctrl.len = LEN_WSUM;
            end
            ST_RCB: begin
                mul_a        = OPND_W'(fmag0);
                mul_b        = OPND_W'(fmag1);
                mul_ctrl.len = LEN_FIRST;
            end
            default: begin
                mul_ctrl.start = 1'b0;
            end
        endcase
    end

    // Divider operand selection; numerators are left aligned in 128 bits.
    always_comb begin
        div_ctrl       = '0;
        div_num        = '0;
        div_den        = w2_reg;
        div_ctrl.start = !wait_reg;
        case (state_reg)
            ST_RMEAN: begin
                div_num      = {fmag0, 8'd0, 72'd0};
                div_den      = w32;
                div_ctrl.len = LEN_MEAN;
            end
            ST_RVDIV, ST_RCDIV: begin
                div_num      = {diff_abs[MAG_W-1:0], 8'd0, 23'd0};
                div_ctrl.len = LEN_WIDE;
            end
            default: begin
                div_ctrl.start = 1'b0;
            end
        endcase
    end

    // Result encodings for the quotient just finished.
    always_comb begin
        mean_enc = enc_signed(fs_reg[0][FIRST_W-1], div_big, div_q, MEAN_LIM);
        var_enc  = enc_unsigned(diff_neg, div_big, div_q, VAR_MAX);
        cov_enc  = enc_signed(diff_neg, div_big, div_q, COV_LIM);
        op_done  = wait_reg && (mul_done || div_done);
    end

    wma_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (mul_ctrl),
        .op_a    (mul_a),
        .op_b    (mul_b),
        .done    (mul_done),
        .product (mul_prod)
    );

    wma_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (div_ctrl),
        .num     (div_num),
        .den     (div_den),
        .done    (div_done),
        .quot    (div_q),
        .big     (div_big)
    );

    // Sequencer, accumulators and output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            wait_reg    <= 1'b0;
            idx_reg     <= '0;
            sub_reg     <= '0;
            count_reg   <= '0;
            ws_reg      <= '0;
            m_valid_reg <= 1'b0;
            for (int k = 0; k < 3; k++) begin
                fs_reg[k] <= '0;
                sq_reg[k] <= '0;
                cr_reg[k] <= '0;
            end
        end else begin
            if (state_reg != ST_IDLE && state_reg != ST_RBEGIN && state_reg != ST_DONE) begin
                if (!wait_reg) begin
                    wait_reg <= 1'b1;
                end else if (mul_done || div_done) begin
                    wait_reg <= 1'b0;
                end
            end

            // Output register takes a new result once the old one is gone.
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE: begin
                    if (s_accept) begin
                        kind_reg <= kind_t'(s_kind);
                        w_in_reg <= w_in;
                        p_reg[0] <= OPND_W'($signed(s_pos_x[COORD_BITS-1:0]));
                        p_reg[1] <= OPND_W'($signed(s_pos_y[COORD_BITS-1:0]));
                        p_reg[2] <= OPND_W'($signed(s_pos_z[COORD_BITS-1:0]));
                        idx_reg  <= '0;
                        sub_reg  <= '0;
                        case (kind_t'(s_kind))
                            KIND_CLEAR: begin
                                err_reg   <= 1'b0;
                                state_reg <= ST_RBEGIN;
                                count_reg <= '0;
                                ws_reg    <= '0;
                                for (int k = 0; k < 3; k++) begin
                                    fs_reg[k] <= '0;
                                    sq_reg[k] <= '0;
                                    cr_reg[k] <= '0;
                                end
                            end
                            KIND_ADD: begin
                                err_reg   <= add_err;
                                state_reg <= add_err ? ST_RBEGIN : ST_UPD;
                            end
                            KIND_SUB: begin
                                err_reg   <= sub_err;
                                state_reg <= sub_err ? ST_RBEGIN : ST_UPD;
                            end
                            default: begin
                                err_reg   <= 1'b1;
                                state_reg <= ST_RBEGIN;
                            end
                        endcase
                    end
                end

                // Five products per axis; the sums rotate so axis i sits at place 0.
                ST_UPD: begin
                    if (op_done) begin
                        sub_reg <= (sub_reg == 3'd4) ? 3'd0 : sub_reg + 1'b1;
                        case (sub_reg)
                            3'd0: begin
                                fs_reg[0] <= is_add ? fs_reg[0] + mul_prod[FIRST_W-1:0]
                                                    : fs_reg[0] - mul_prod[FIRST_W-1:0];
                            end
                            3'd2: begin
                                sq_reg[0] <= is_add ? sq_reg[0] + mul_prod[SUM_W-1:0]
                                                    : sq_reg[0] - mul_prod[SUM_W-1:0];
                            end
                            3'd4: begin
                                p_reg[0]  <= p_reg[1];
                                p_reg[1]  <= p_reg[2];
                                p_reg[2]  <= p_reg[0];
                                fs_reg[0] <= fs_reg[1];
                                fs_reg[1] <= fs_reg[2];
                                fs_reg[2] <= fs_reg[0];
                                sq_reg[0] <= sq_reg[1];
                                sq_reg[1] <= sq_reg[2];
                                sq_reg[2] <= sq_reg[0];
                                cr_reg[0] <= cr_reg[1];
                                cr_reg[1] <= cr_reg[2];
                                cr_reg[2] <= is_add ? cr_reg[0] + mul_prod[SUM_W-1:0]
                                                    : cr_reg[0] - mul_prod[SUM_W-1:0];
                                if (idx_reg == 2'd2) begin
                                    idx_reg   <= '0;
                                    state_reg <= ST_RBEGIN;
                                    ws_reg    <= is_add ? ws_reg + WTOT_W'(w_in_reg)
                                                        : ws_reg - WTOT_W'(w_in_reg);
                                    count_reg <= is_add ? count_reg + 1'b1
                                                        : count_reg - 1'b1;
                                end else begin
                                    idx_reg   <= idx_reg + 1'b1;
                                end
                            end
                            default: begin
                                t_reg <= mul_prod[OPND_W-1:0];
                            end
                        endcase
                    end
                end

                ST_RBEGIN: begin
                    zero_reg  <= (ws_reg == '0);
                    idx_reg   <= '0;
                    state_reg <= (ws_reg == '0) ? ST_DONE : ST_RW2;
                end

                ST_RW2: begin
                    if (op_done) begin
                        w2_reg    <= mul_prod[OPND_W-1:0];
                        state_reg <= ST_RMEAN;
                    end
                end

                ST_RMEAN: begin
                    if (op_done) begin
                        mean_st_reg[idx_reg] <= mean_enc[MEAN_W-1:0];
                        state_reg <= ST_RVA;
                    end
                end

                ST_RVA, ST_RCA: begin
                    if (op_done) begin
                        pa_reg    <= mul_prod[PART_W-1:0];
                        state_reg <= (state_reg == ST_RVA) ? ST_RVB : ST_RCB;
                    end
                end

                ST_RVB, ST_RCB: begin
                    if (op_done) begin
                        pb_reg    <= mul_prod[PART_W-1:0];
                        state_reg <= (state_reg == ST_RVB) ? ST_RVDIV : ST_RCDIV;
                    end
                end

                ST_RVDIV: begin
                    if (op_done) begin
                        var_st_reg[idx_reg] <= var_enc[VAR_W-1:0];
                        state_reg <= ST_RCA;
                    end
                end

                // Last quotient of an axis; rotate the sums to the next one.
                ST_RCDIV: begin
                    if (op_done) begin
                        cov_st_reg[idx_reg] <= cov_enc[COV_W-1:0];
                        fs_reg[0] <= fs_reg[1];
                        fs_reg[1] <= fs_reg[2];
                        fs_reg[2] <= fs_reg[0];
                        sq_reg[0] <= sq_reg[1];
                        sq_reg[1] <= sq_reg[2];
                        sq_reg[2] <= sq_reg[0];
                        cr_reg[0] <= cr_reg[1];
                        cr_reg[1] <= cr_reg[2];
                        cr_reg[2] <= cr_reg[0];
                        idx_reg   <= idx_reg + 1'b1;
                        state_reg <= (idx_reg == 2'd2) ? ST_DONE : ST_RMEAN;
                    end
                end

                ST_DONE: begin
                    if (out_load) begin
                        m_error_reg        <= err_reg;
                        m_hit_count_reg    <= COUNT_W'(count_reg);
                        m_weight_total_reg <= ws_reg;
                        for (int k = 0; k < 3; k++) begin
                            m_mean_reg[k] <= zero_reg ? '0 : mean_st_reg[k];
                            m_var_reg[k]  <= zero_reg ? '0 : var_st_reg[k];
                            m_cov_reg[k]  <= zero_reg ? '0 : cov_st_reg[k];
                        end
                        state_reg <= ST_IDLE;
                    end
                end

                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_error        = m_error_reg;
    assign m_hit_count    = m_hit_count_reg;
    assign m_weight_total = m_weight_total_reg;
    assign m_mean_x       = m_mean_reg[0];
    assign m_mean_y       = m_mean_reg[1];
    assign m_mean_z       = m_mean_reg[2];
    assign m_var_x        = m_var_reg[0];
    assign m_var_y        = m_var_reg[1];
    assign m_var_z        = m_var_reg[2];
    assign m_cov_xy       = m_cov_reg[0];
    assign m_cov_yz       = m_cov_reg[1];
    assign m_cov_zx       = m_cov_reg[2];

`ifndef NO_ASSERTIONS
    // The two serial units are never finishing in the same cycle.
    assert property (@(posedge aclk) disable iff (!aresetn) !(mul_done && div_done))
        else $error("multiplier and divider finished together");

    // A clear transfer empties the count and the weight sum.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && s_kind == KIND_CLEAR) |=> (count_reg == '0 && ws_reg == '0))
        else $error("clear left state behind");

    // A rejected item leaves the count untouched.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RBEGIN && err_reg) |-> $stable(count_reg))
        else $error("rejected item changed the count");

    // Zeroed statistics are only reported with an empty weight sum.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (out_load && zero_reg) |-> (ws_reg == '0))
        else $error("statistics zeroed with nonzero weight sum");
`endif

endmodule
